// File: hw/rtl/pmt_pkg.sv
package pmt_pkg;

	// limit registers and timer geometry
	localparam int LIMIT_W        = 20;
	localparam int N_TIMERS       = 5;
	localparam int TIMER_BITS_DEF = 20;
	localparam int CFG_IDX_W      = 3;

	// timer slots, in check order
	localparam int T_STILL = 0;
	localparam int T_ALARM = 1;
	localparam int T_LOCK  = 2;
	localparam int T_IDLE  = 3;
	localparam int T_WAKE  = 4;

	localparam logic [LIMIT_W-1:0] STILL_LIMIT_RST = LIMIT_W'(60000);
	localparam logic [LIMIT_W-1:0] ALARM_LIMIT_RST = LIMIT_W'(10000);
	localparam logic [LIMIT_W-1:0] LOCK_LIMIT_RST  = LIMIT_W'(60000);
	localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST  = LIMIT_W'(15000);
	localparam logic [LIMIT_W-1:0] WAKE_LIMIT_RST  = LIMIT_W'(60000);

	typedef enum logic [2:0] {
		PS_SLEEP    = 3'd0,
		PS_PARKED   = 3'd1,
		PS_UNLOCKED = 3'd2,
		PS_PAIRED   = 3'd3,
		PS_SOLO     = 3'd4,
		PS_RIDING   = 3'd5,
		PS_NAP      = 3'd6,
		PS_ALARM    = 3'd7
	} pwr_state_t;

	typedef enum logic [2:0] {
		REQ_MOTION = 3'd0,
		REQ_CODE   = 3'd1,
		REQ_LINK   = 3'd2,
		REQ_NAP    = 3'd3,
		REQ_WAKE   = 3'd4,
		REQ_TAP    = 3'd5,
		REQ_TICK   = 3'd6,
		REQ_COMMIT = 3'd7
	} req_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STILL_LIMIT = 3'd0,
		CFG_ALARM_LIMIT = 3'd1,
		CFG_LOCK_LIMIT  = 3'd2,
		CFG_IDLE_LIMIT  = 3'd3,
		CFG_WAKE_LIMIT  = 3'd4
	} cfg_reg_t;

	localparam logic [1:0] DISP_LAST = 2'd2;

	typedef struct packed {
		logic [2:0] req_type;
		logic       moving;
		logic       link_up;
	} pmt_evt_t;

	typedef struct packed {
		logic [2:0]          power_state;
		logic [2:0]          pending_state;
		logic [1:0]          display_mode;
		logic [N_TIMERS-1:0] timers_running;
		logic [N_TIMERS-1:0] timeouts_fired;
	} pmt_res_t;

endpackage

// File: hw/rtl/power_mode_timer_fsm.sv
// power-mode controller: keeps a committed and a pending power state, five
// millisecond timers (stillness, alarm, lock, idle, wakeup) and a display
// mode. every event word gives exactly one result word carrying the state
// after that event. events are registered on entry, then one pass of update
// logic (timer increment, in-order timeout checks and their handlers) writes
// the state and a two-word result buffer. one event per cycle is taken
// unless the event side stalls; a result is offered once its event leaves
// the input register. the event side stalls only while an event is held and
// the result buffer is full. limit registers must be written via the config
// port only while the block is idle (unenforced); cfg_ready is always high.
module power_mode_timer_fsm
	import pmt_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  pmt_evt_t             evt,

	output logic                 res_valid,
	input  logic                 res_stall,
	output pmt_res_t             res,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data
);

	// compare width covers both the count and the limit
	localparam int CW = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

	// limit registers
	logic [LIMIT_W-1:0] limit_q [N_TIMERS];

	// architectural state
	pwr_state_t          cur_q, pend_q;
	logic [1:0]          disp_q;
	logic [N_TIMERS-1:0] on_q;
	logic [TIMER_BITS-1:0] el_q [N_TIMERS];

	// input register
	logic     evt_valid_s1;
	pmt_evt_t evt_s1;

	// result buffer, slot 0 is the head
	pmt_res_t res_buf_q [2];
	logic [1:0] res_cnt_q;

	// next-state values
	pwr_state_t            cur_n, pend_n;
	logic [1:0]            disp_n;
	logic [N_TIMERS-1:0]   on_n, fired_n;
	logic [TIMER_BITS-1:0] el_n [N_TIMERS];
	pmt_res_t              res_new;
	req_code_t             req;

	logic buf_full, push, pop, evt_take;

	assign cfg_ready = 1'b1;

	// limit register writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q[T_STILL] <= STILL_LIMIT_RST;
			limit_q[T_ALARM] <= ALARM_LIMIT_RST;
			limit_q[T_LOCK]  <= LOCK_LIMIT_RST;
			limit_q[T_IDLE]  <= IDLE_LIMIT_RST;
			limit_q[T_WAKE]  <= WAKE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_STILL_LIMIT: limit_q[T_STILL] <= cfg_data;
				CFG_ALARM_LIMIT: limit_q[T_ALARM] <= cfg_data;
				CFG_LOCK_LIMIT:  limit_q[T_LOCK]  <= cfg_data;
				CFG_IDLE_LIMIT:  limit_q[T_IDLE]  <= cfg_data;
				CFG_WAKE_LIMIT:  limit_q[T_WAKE]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: the held event moves on whenever the buffer has room
	assign buf_full  = (res_cnt_q == 2'd2);
	assign push      = evt_valid_s1 && !buf_full;
	assign evt_stall = evt_valid_s1 && buf_full;
	assign evt_take  = evt_valid && !evt_stall;
	assign res_valid = (res_cnt_q != 2'd0);
	assign pop       = res_valid && !res_stall;
	assign res       = res_buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt_take) begin
			evt_valid_s1 <= 1'b1;
		end else if (push) begin
			evt_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			evt_s1 <= evt;
		end
	end

	assign req = req_code_t'(evt_s1.req_type);

	// next-state logic: one pass over the held event
	always_comb begin
		cur_n   = cur_q;
		pend_n  = pend_q;
		disp_n  = disp_q;
		on_n    = on_q;
		fired_n = '0;
		for (int t = 0; t < N_TIMERS; t++) begin
			el_n[t] = el_q[t];
		end

		unique case (req)
			REQ_MOTION: begin
				unique case (cur_q)
					PS_SLEEP: begin
						if (evt_s1.moving) begin
							el_n[T_WAKE] = '0;
							on_n[T_WAKE] = 1'b0;
							pend_n = PS_PARKED;
							el_n[T_ALARM] = '0;
							on_n[T_ALARM] = 1'b1;
						end
					end
					PS_PARKED: begin
						if (evt_s1.moving) begin
							el_n[T_IDLE] = '0;
							on_n[T_IDLE] = 1'b0;
							if (!on_q[T_ALARM]) begin
								el_n[T_ALARM] = '0;
								on_n[T_ALARM] = 1'b1;
							end
						end else begin
							el_n[T_ALARM] = '0;
							on_n[T_ALARM] = 1'b0;
							if (!on_q[T_IDLE]) begin
								el_n[T_IDLE] = '0;
								on_n[T_IDLE] = 1'b1;
							end
						end
					end
					PS_UNLOCKED, PS_PAIRED: begin
						if (evt_s1.moving) begin
							el_n[T_LOCK] = '0;
							on_n[T_LOCK] = 1'b0;
							pend_n = (cur_q == PS_UNLOCKED) ? PS_SOLO : PS_RIDING;
						end else if (!on_q[T_LOCK]) begin
							el_n[T_LOCK] = '0;
							on_n[T_LOCK] = 1'b1;
						end
					end
					PS_ALARM, PS_SOLO, PS_RIDING: begin
						if (evt_s1.moving) begin
							el_n[T_STILL] = '0;
							on_n[T_STILL] = 1'b0;
						end else if (!on_q[T_STILL]) begin
							el_n[T_STILL] = '0;
							on_n[T_STILL] = 1'b1;
						end
					end
					default: ;
				endcase
			end
			REQ_CODE: begin
				if (cur_q == PS_ALARM || cur_q == PS_PARKED) begin
					pend_n = PS_UNLOCKED;
					el_n[T_STILL] = '0;
					on_n[T_STILL] = 1'b0;
					el_n[T_IDLE]  = '0;
					on_n[T_IDLE]  = 1'b0;
					el_n[T_LOCK]  = '0;
					on_n[T_LOCK]  = 1'b1;
				end
			end
			REQ_LINK: begin
				unique case (cur_q)
					PS_PARKED: begin
						if (evt_s1.link_up) begin
							pend_n = PS_PAIRED;
							el_n[T_IDLE] = '0;
							on_n[T_IDLE] = 1'b0;
							el_n[T_LOCK] = '0;
							on_n[T_LOCK] = 1'b1;
						end
					end
					PS_UNLOCKED: if (evt_s1.link_up)  pend_n = PS_PAIRED;
					PS_PAIRED:   if (!evt_s1.link_up) pend_n = PS_UNLOCKED;
					PS_SOLO:     if (evt_s1.link_up)  pend_n = PS_RIDING;
					PS_RIDING:   if (!evt_s1.link_up) pend_n = PS_SOLO;
					default: ;
				endcase
			end
			REQ_NAP: begin
				if (cur_q == PS_PAIRED || cur_q == PS_RIDING) begin
					pend_n = PS_NAP;
					el_n[T_WAKE] = '0;
					on_n[T_WAKE] = 1'b1;
				end
			end
			REQ_WAKE: begin
				if (cur_q == PS_NAP) pend_n = PS_RIDING;
			end
			REQ_TAP: begin
				disp_n = (disp_q < DISP_LAST) ? disp_q + 2'd1 : 2'd0;
			end
			REQ_TICK: begin
				// advance running timers, saturating
				for (int t = 0; t < N_TIMERS; t++) begin
					if (on_n[t] && el_n[t] != CNT_MAX) el_n[t] = el_n[t] + 1'b1;
				end
				// check in order; a handler may start a later timer
				for (int t = 0; t < N_TIMERS; t++) begin
					if (on_n[t] && (CW'(el_n[t]) >= CW'(limit_q[t]))) begin
						el_n[t]    = '0;
						on_n[t]    = 1'b0;
						fired_n[t] = 1'b1;
						case (t)
							T_STILL: begin
								if (cur_q == PS_SOLO) begin
									pend_n = PS_UNLOCKED;
									el_n[T_LOCK] = '0;
									on_n[T_LOCK] = 1'b1;
								end else if (cur_q == PS_RIDING) begin
									pend_n = PS_PAIRED;
									el_n[T_LOCK] = '0;
									on_n[T_LOCK] = 1'b1;
								end else if (cur_q == PS_ALARM) begin
									pend_n = PS_PARKED;
									el_n[T_IDLE] = '0;
									on_n[T_IDLE] = 1'b1;
								end
							end
							T_ALARM: begin
								if (cur_q == PS_PARKED) pend_n = PS_ALARM;
							end
							T_LOCK: begin
								if (cur_q == PS_UNLOCKED || cur_q == PS_PAIRED) begin
									pend_n = PS_PARKED;
									el_n[T_IDLE] = '0;
									on_n[T_IDLE] = 1'b1;
								end
							end
							T_IDLE: begin
								if (cur_q == PS_PARKED) begin
									pend_n = PS_SLEEP;
									el_n[T_WAKE] = '0;
									on_n[T_WAKE] = 1'b1;
								end
							end
							default: begin
								if (cur_q == PS_SLEEP) begin
									pend_n = PS_PARKED;
									el_n[T_IDLE] = '0;
									on_n[T_IDLE] = 1'b1;
								end else if (cur_q == PS_NAP) begin
									pend_n = PS_RIDING;
								end
							end
						endcase
					end
				end
			end
			REQ_COMMIT: begin
				cur_n = pend_q;
			end
			default: ;
		endcase
	end

	// result word built from the updated state
	always_comb begin
		res_new.power_state    = 3'(cur_n);
		res_new.pending_state  = 3'(pend_n);
		res_new.display_mode   = disp_n;
		res_new.timers_running = on_n;
		res_new.timeouts_fired = fired_n;
	end

	// state registers, updated once per event as it leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= PS_SLEEP;
			pend_q <= PS_SLEEP;
			disp_q <= 2'd0;
			on_q   <= N_TIMERS'(1) << T_WAKE;
			for (int t = 0; t < N_TIMERS; t++) begin
				el_q[t] <= '0;
			end
		end else if (push) begin
			cur_q  <= cur_n;
			pend_q <= pend_n;
			disp_q <= disp_n;
			on_q   <= on_n;
			for (int t = 0; t < N_TIMERS; t++) begin
				el_q[t] <= el_n[t];
			end
		end
	end

	// two-word result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (res_cnt_q == 2'd0) res_buf_q[0] <= res_new;
				else                   res_buf_q[1] <= res_new;
			end
			2'b01: begin
				res_buf_q[0] <= res_buf_q[1];
			end
			2'b11: begin
				// only reachable with one word held
				res_buf_q[0] <= res_new;
			end
			default: ;
		endcase
	end

endmodule

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pmt_pkg::*;

	// counter width of the timers, kept at the block's default
	localparam int CNT_W          = TIMER_BITS_DEF;
	// cycles with no word moving on any port before the run is declared hung
	localparam int WATCHDOG_LIMIT = 4000;
	// settle time after the last result
	localparam int END_SETTLE     = 10;
	// long receiver hold-off used to fill the block up
	localparam int HOLD_OFF_LEN   = 120;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

	// clock and reset
	logic clk;
	logic arst_n = 1'b0;

	// event side, driven by the sender
	logic     evt_valid = 1'b0;
	logic     evt_stall;
	pmt_evt_t evt       = '0;

	// result side, stall driven by the receiver
	logic     res_valid;
	logic     res_stall = 1'b0;
	pmt_res_t res;

	// limit register write port
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMIT_W-1:0]   cfg_data  = '0;

	// idle percentages for both sides, and the hold-off request
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int res_hold_left = 0;

	int mismatches   = 0;
	int quiet_cycles = 0;

	// result words predicted for accepted events, oldest first
	pmt_res_t expected_reports[$];

	// shadow copy of the controller state
	pwr_state_t          model_committed;
	pwr_state_t          model_pending;
	logic [1:0]          model_disp;
	logic [CNT_W-1:0]    model_elapsed [N_TIMERS];
	logic [N_TIMERS-1:0] model_on;
	logic [LIMIT_W-1:0]  model_limit [N_TIMERS];

	power_mode_timer_fsm #(
		.TIMER_BITS(CNT_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// shadow model of the power-mode controller
	// ---------------------------------------------------------------

	// a (re)started timer always counts from zero
	function automatic void restart_timer(int t);
		model_elapsed[t] = '0;
		model_on[t]      = 1'b1;
	endfunction

	function automatic void halt_timer(int t);
		model_elapsed[t] = '0;
		model_on[t]      = 1'b0;
	endfunction

	// applies one event word to the shadow state, returns the result word
	function automatic pmt_res_t predict_report(pmt_evt_t ev);
		pmt_res_t            rep;
		logic [N_TIMERS-1:0] fired;
		int                  t;
		fired = '0;
		case (req_code_t'(ev.req_type))
		REQ_MOTION: begin
			case (model_committed)
			PS_SLEEP: begin
				// first motion makes parked the pending state, with the alarm armed
				if (ev.moving) begin
					halt_timer(T_WAKE);
					model_pending = PS_PARKED;
					restart_timer(T_ALARM);
				end
			end
			PS_PARKED: begin
				// motion keeps the alarm timer going, stillness runs idle instead
				if (ev.moving) begin
					halt_timer(T_IDLE);
					if (!model_on[T_ALARM]) restart_timer(T_ALARM);
				end else begin
					halt_timer(T_ALARM);
					if (!model_on[T_IDLE]) restart_timer(T_IDLE);
				end
			end
			PS_UNLOCKED, PS_PAIRED: begin
				if (ev.moving) begin
					halt_timer(T_LOCK);
					model_pending = (model_committed == PS_UNLOCKED) ? PS_SOLO : PS_RIDING;
				end else if (!model_on[T_LOCK]) begin
					restart_timer(T_LOCK);
				end
			end
			PS_ALARM, PS_SOLO, PS_RIDING: begin
				if (ev.moving) halt_timer(T_STILL);
				else if (!model_on[T_STILL]) restart_timer(T_STILL);
			end
			default: ;
			endcase
		end
		REQ_CODE: begin
			if (model_committed == PS_ALARM || model_committed == PS_PARKED) begin
				model_pending = PS_UNLOCKED;
				halt_timer(T_STILL);
				halt_timer(T_IDLE);
				restart_timer(T_LOCK);
			end
		end
		REQ_LINK: begin
			case (model_committed)
			PS_PARKED: begin
				if (ev.link_up) begin
					model_pending = PS_PAIRED;
					halt_timer(T_IDLE);
					restart_timer(T_LOCK);
				end
			end
			PS_UNLOCKED: if (ev.link_up) model_pending = PS_PAIRED;
			PS_PAIRED:   if (!ev.link_up) model_pending = PS_UNLOCKED;
			PS_SOLO:     if (ev.link_up) model_pending = PS_RIDING;
			PS_RIDING:   if (!ev.link_up) model_pending = PS_SOLO;
			default: ;
			endcase
		end
		REQ_NAP: begin
			if (model_committed == PS_PAIRED || model_committed == PS_RIDING) begin
				model_pending = PS_NAP;
				restart_timer(T_WAKE);
			end
		end
		REQ_WAKE: begin
			if (model_committed == PS_NAP) model_pending = PS_RIDING;
		end
		REQ_TAP: begin
			// three-mode cycle, anything past the last mode goes back to zero
			model_disp = (model_disp < DISP_LAST) ? model_disp + 2'd1 : 2'd0;
		end
		REQ_TICK: begin
			// advance every running timer, saturating at full scale
			for (t = 0; t < N_TIMERS; t++) begin
				if (model_on[t] && model_elapsed[t] != {CNT_W{1'b1}})
					model_elapsed[t] = model_elapsed[t] + 1'b1;
			end
			// check in slot order; a handler may restart a later slot, which
			// can then expire in this same tick when its limit is zero
			for (t = 0; t < N_TIMERS; t++) begin
				if (model_on[t] && model_elapsed[t] >= model_limit[t]) begin
					halt_timer(t);
					fired[t] = 1'b1;
					case (t)
					T_STILL: begin
						if (model_committed == PS_SOLO) begin
							model_pending = PS_UNLOCKED;
							restart_timer(T_LOCK);
						end else if (model_committed == PS_RIDING) begin
							model_pending = PS_PAIRED;
							restart_timer(T_LOCK);
						end else if (model_committed == PS_ALARM) begin
							model_pending = PS_PARKED;
							restart_timer(T_IDLE);
						end
					end
					T_ALARM: begin
						if (model_committed == PS_PARKED) model_pending = PS_ALARM;
					end
					T_LOCK: begin
						if (model_committed == PS_UNLOCKED || model_committed == PS_PAIRED) begin
							model_pending = PS_PARKED;
							restart_timer(T_IDLE);
						end
					end
					T_IDLE: begin
						if (model_committed == PS_PARKED) begin
							model_pending = PS_SLEEP;
							restart_timer(T_WAKE);
						end
					end
					default: begin
						// periodic wakeup
						if (model_committed == PS_SLEEP) begin
							model_pending = PS_PARKED;
							restart_timer(T_IDLE);
						end else if (model_committed == PS_NAP) begin
							model_pending = PS_RIDING;
						end
					end
					endcase
				end
			end
		end
		default: begin
			// commit
			model_committed = model_pending;
		end
		endcase
		rep.power_state    = model_committed;
		rep.pending_state  = model_pending;
		rep.display_mode   = model_disp;
		rep.timers_running = model_on;
		rep.timeouts_fired = fired;
		return rep;
	endfunction

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	function automatic void check_field(string name, logic [4:0] want, logic [4:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// every accepted result word is matched against the oldest prediction
	always @(posedge clk) begin
		pmt_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_reports.size() == 0) begin
				$error("result word with no prediction waiting: %p", res);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("power_state", want.power_state, res.power_state);
				check_field("pending_state", want.pending_state, res.pending_state);
				check_field("display_mode", want.display_mode, res.display_mode);
				check_field("timers_running", want.timers_running, res.timers_running);
				check_field("timeouts_fired", want.timeouts_fired, res.timeouts_fired);
			end
		end
	end

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (res_hold_left > 0) begin
			res_stall <= 1'b1;
			res_hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// hang detection: counts cycles in which no word moves anywhere
	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// offers one event word, with a random gap first, and predicts its
	// result once the word has been taken
	task automatic offer_event(input pmt_evt_t ev);
		while ($urandom_range(99) < send_idle_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= ev;
		do @(posedge clk); while (evt_stall);
		expected_reports.push_back(predict_report(ev));
	endtask

	// sender stops and waits until every predicted result has come back
	task automatic await_reports_drained();
		evt_valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
	endtask

	// one register write; valid is left high so back-to-back writes stay
	// one assignment per edge, the caller lowers it
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < N_TIMERS) model_limit[idx] = value;
	endtask

	// writes every limit register with a value drawn from [lo, hi]
	task automatic program_limits(input int unsigned lo, input int unsigned hi);
		int i;
		for (i = 0; i < N_TIMERS; i++)
			cfg_write(cfg_reg_t'(i), LIMIT_W'($urandom_range(hi, lo)));
		cfg_valid <= 1'b0;
	endtask

	function automatic pmt_evt_t random_event();
		pmt_evt_t ev;
		int       roll;
		roll       = $urandom_range(99);
		ev.moving  = 1'($urandom);
		ev.link_up = 1'($urandom);
		// commits are frequent so pending moves become committed and the
		// walk gets past sleep and parked
		if (roll < 25)      ev.req_type = REQ_TICK;
		else if (roll < 45) ev.req_type = REQ_COMMIT;
		else if (roll < 62) ev.req_type = REQ_MOTION;
		else if (roll < 70) ev.req_type = REQ_CODE;
		else if (roll < 79) ev.req_type = REQ_LINK;
		else if (roll < 86) ev.req_type = REQ_NAP;
		else if (roll < 93) ev.req_type = REQ_WAKE;
		else                ev.req_type = REQ_TAP;
		return ev;
	endfunction

	// random words with occasional runs of ticks so small limits expire
	task automatic run_random(input int count);
		int       sent;
		int       burst;
		pmt_evt_t ev;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 15) begin
				burst = $urandom_range(12, 2);
				repeat (burst) begin
					ev          = random_event();
					ev.req_type = REQ_TICK;
					offer_event(ev);
				end
				sent += burst;
			end else begin
				offer_event(random_event());
				sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	task automatic apply_reset();
		int t;
		model_committed = PS_SLEEP;
		model_pending   = PS_SLEEP;
		model_disp      = '0;
		model_on        = '0;
		model_on[T_WAKE] = 1'b1;
		for (t = 0; t < N_TIMERS; t++) model_elapsed[t] = '0;
		model_limit[T_STILL] = STILL_LIMIT_RST;
		model_limit[T_ALARM] = ALARM_LIMIT_RST;
		model_limit[T_LOCK]  = LOCK_LIMIT_RST;
		model_limit[T_IDLE]  = IDLE_LIMIT_RST;
		model_limit[T_WAKE]  = WAKE_LIMIT_RST;
		// first idling setting: sender idles lightly, receiver heavily
		send_idle_pct = 34;
		recv_idle_pct = 86;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	endtask

	// reset limits; display wrap, ignored events in sleep, a quiet tick
	task automatic test_reset_defaults();
		repeat (4) offer_event('{REQ_TAP, 1'b0, 1'b0});
		offer_event('{REQ_MOTION, 1'b0, 1'b1});
		offer_event('{REQ_CODE, 1'b1, 1'b1});
		offer_event('{REQ_TICK, 1'b0, 1'b0});
		offer_event('{REQ_COMMIT, 1'b0, 1'b0});
	endtask

	// walks sleep, parked, unlocked, solo, riding, nap and back with short limits
	task automatic test_directed_walk();
		await_reports_drained();
		program_limits(2, 2);
		offer_event('{REQ_MOTION, 1'b1, 1'b0});
		offer_event('{REQ_COMMIT, 1'b0, 1'b0});
		offer_event('{REQ_MOTION, 1'b0, 1'b0});
		offer_event('{REQ_LINK, 1'b0, 1'b1});
		offer_event('{REQ_CODE, 1'b0, 1'b0});
		offer_event('{REQ_COMMIT, 1'b0, 1'b0});
		offer_event('{REQ_MOTION, 1'b1, 1'b0});
		offer_event('{REQ_COMMIT, 1'b0, 1'b0});
		offer_event('{REQ_LINK, 1'b0, 1'b1});
		offer_event('{REQ_COMMIT, 1'b0, 1'b0});
		offer_event('{REQ_MOTION, 1'b0, 1'b0});
		offer_event('{REQ_NAP, 1'b1, 1'b1});
		offer_event('{REQ_COMMIT, 1'b0, 1'b0});
		offer_event('{REQ_WAKE, 1'b0, 1'b0});
		// stillness and wakeup both run out on the second tick
		offer_event('{REQ_TICK, 1'b1, 1'b0});
		offer_event('{REQ_TICK, 1'b0, 1'b1});
		offer_event('{REQ_COMMIT, 1'b0, 1'b0});
		offer_event('{REQ_LINK, 1'b1, 1'b0});
		offer_event('{REQ_COMMIT, 1'b0, 1'b0});
	endtask

	// zero limits fire on the next tick and chain within one tick;
	// full-scale limits never fire in a run this short
	task automatic test_limit_extremes();
		await_reports_drained();
		program_limits(0, 0);
		run_random(30);
		await_reports_drained();
		program_limits(LIMIT_MAX, LIMIT_MAX);
		run_random(30);
	endtask

	// writes to indexes past the last register must leave the limits alone
	task automatic test_unmapped_index();
		int i;
		await_reports_drained();
		program_limits(1, 3);
		await_reports_drained();
		for (i = N_TIMERS; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), LIMIT_W'($urandom_range(1, 0)) ? LIMIT_MAX : '0);
		cfg_valid <= 1'b0;
		run_random(30);
	endtask

	// bulk random traffic under the three idling setups
	task automatic test_random_phases();
		await_reports_drained();
		program_limits(0, 10);
		run_random(95);

		await_reports_drained();
		send_idle_pct = 86;
		recv_idle_pct = 34;
		program_limits(1, 6);
		run_random(95);

		await_reports_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_limits(0, 20);
		run_random(95);
	endtask

	// receiver holds off for a long stretch while words keep coming, so the
	// block fills and stalls its input; then the sender waits for all results
	task automatic test_backpressure();
		await_reports_drained();
		program_limits(1, 4);
		res_hold_left = HOLD_OFF_LEN;
		run_random(40);
		await_reports_drained();
		run_random(20);
	endtask

	initial begin
		apply_reset();
		test_reset_defaults();
		test_directed_walk();
		test_limit_extremes();
		test_unmapped_index();
		test_random_phases();
		test_backpressure();
		await_reports_drained();
		// let any stray result word show up before the verdict
		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
